// ----- hdl/radix_integer_to_text_top_defines.svh -----
// Assertion macros shared by the radix integer-to-text block.
// Depends on nothing; included by the top level.
`ifndef RADIX_INTEGER_TO_TEXT_TOP_DEFINES_SVH
`define RADIX_INTEGER_TO_TEXT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rit check failed");

// Next-cycle implication, disabled during reset.
`define RIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rit check failed");

`endif

// ----- hdl/rit_pkg.sv -----
// Types, constants and the digit-to-ASCII mapping for the radix text block.
// No dependencies.
package rit_pkg;

   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 7;
   localparam int REM_W   = RADIX_W + 1;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam int                 DECIMAL_TEN = 10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT_SIGN,
      ST_EMIT_ZERO,
      ST_EMIT_DIGIT
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit);
      logic [CHAR_W-1:0] wide;
      wide = {1'b0, digit};
      if (digit < RADIX_W'(DECIMAL_TEN)) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A + wide - CHAR_W'(DECIMAL_TEN);
   endfunction

endpackage

// ----- hdl/rit_divider.sv -----
// Restoring divider: one quotient bit per cycle while busy.
// Depends on rit_pkg.
module rit_divider #(
   parameter int VALUE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_BITS-1:0]        dividend,
   input  logic [rit_pkg::RADIX_W-1:0]  divisor,
   output logic                         done,
   output logic [VALUE_BITS-1:0]        quotient,
   output logic [rit_pkg::RADIX_W-1:0]  remainder
);
   import rit_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W-1:0]      shifted;
   logic                  fits;

   always_comb begin
      shifted  = {rem_ff[RADIX_W-1:0], quo_ff[VALUE_BITS-1]};
      fits     = shifted >= {1'b0, divisor};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = LAST_STEP;
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? shifted - {1'b0, divisor} : shifted;
         quo_in   = {quo_ff[VALUE_BITS-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[RADIX_W-1:0];

endmodule

// ----- hdl/radix_integer_to_text_top.sv -----
// Radix integer-to-text converter: sequencer, digit store and output register.
// Depends on rit_pkg, rit_divider and radix_integer_to_text_top_defines.svh.
//
// Usage:
//   req_valid/req_number present one signed integer; it is taken when req_stall
//   is low. rsp_valid/rsp_character/rsp_last_char/rsp_bad_radix return the
//   text one character per beat, most significant first; rsp_last_char marks
//   the final beat of a number. csr_wr_en/csr_wr_data set the radix; write it
//   only while no conversion is in flight.
// Sequencing:
//   each digit costs one restoring divide on the shared divider; the digits
//   are stored, then emitted as characters. A bad radix skips the divides.
//   req_stall stays high from acceptance until the last character is loaded
//   into the output register.
// Reset: synchronous; radix returns to 10, output register empties.
// Stall: the output register holds its beat and the sequencer waits.
`include "radix_integer_to_text_top_defines.svh"

module radix_integer_to_text_top #(
   parameter int VALUE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rit_pkg::RADIX_W-1:0]  csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rit_pkg::CHAR_W-1:0]   rsp_character,
   output logic                         rsp_last_char,
   output logic                         rsp_bad_radix
);
   import rit_pkg::*;

   localparam int IDX_W = $clog2(VALUE_BITS);

   state_type             state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  lead_ff, lead_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [RADIX_W-1:0]    digit_mem_ff [VALUE_BITS];
   logic [RADIX_W-1:0]    digit_rd_ff;
   logic                  digit_we;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic                  req_beat;
   logic                  out_free;
   logic                  load;
   logic                  radix_bad;
   logic [VALUE_BITS-1:0] raw;
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [RADIX_W-1:0]    div_rem;

   rit_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign radix_bad = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
   assign raw       = req_number;

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      lead_in     = lead_ff;
      idx_in      = idx_ff;
      digit_we    = 1'b0;
      div_start   = 1'b0;
      load        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in  = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               neg_in  = raw[VALUE_BITS-1];
               mag_in  = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               lead_in = raw[VALUE_BITS-1] || (raw < VALUE_BITS'(DECIMAL_TEN));
               idx_in  = '0;
               state_in = radix_bad ? ST_BAD : ST_DIV_START;
            end
         end
         ST_BAD: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_NUL;
               rsp_last_in = 1'b1;
               rsp_bad_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               digit_we = 1'b1;
               mag_in   = div_quo;
               if (div_quo == '0) begin
                  // idx now points at the most significant digit
                  if (neg_ff) begin
                     state_in = ST_EMIT_SIGN;
                  end else if (lead_ff) begin
                     state_in = ST_EMIT_ZERO;
                  end else begin
                     state_in = ST_EMIT_DIGIT;
                  end
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_EMIT_SIGN: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               rsp_bad_in  = 1'b0;
               state_in    = lead_ff ? ST_EMIT_ZERO : ST_EMIT_DIGIT;
            end
         end
         ST_EMIT_ZERO: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_ZERO;
               rsp_last_in = 1'b0;
               rsp_bad_in  = 1'b0;
               state_in    = ST_EMIT_DIGIT;
            end
         end
         ST_EMIT_DIGIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = digit_to_ascii(digit_rd_ff);
               rsp_last_in = (idx_ff == '0);
               rsp_bad_in  = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      lead_ff     <= lead_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // Read ahead at the next index; forward the digit written at that same index.
   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_mem_ff[idx_ff] <= div_rem;
      end
      if (digit_we && (idx_in == idx_ff)) begin
         digit_rd_ff <= div_rem;
      end else begin
         digit_rd_ff <= digit_mem_ff[idx_in];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   `RIT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, req_stall)
   `RIT_ASSERT_NOW(a_bad_beat_shape, clock, reset, rsp_valid && rsp_bad_radix,
      rsp_last_char && (rsp_character == CHAR_NUL))
   `RIT_ASSERT_NOW(a_rem_below_radix, clock, reset, div_done, div_rem < radix_ff)
   `RIT_ASSERT_NOW(a_digit_in_range, clock, reset, state_ff == ST_EMIT_DIGIT,
      digit_rd_ff < radix_ff)

endmodule
